[src/rss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, codes and constants of the rotated sprite sampler.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Default sprite store size in bytes.
  localparam int STORE_BYTES_DEF = 2048;

  // Field widths of the request and result channels.
  localparam int ADDR_IN_W = 11;
  localparam int COORD_W   = 8;
  localparam int COLOR_W   = 16;
  localparam int TRIG_W    = 16;

  // Fraction bits of the Q2.14 cosine and sine.
  localparam int Q_FRAC = 14;

  // Width of a computed byte index: row * bytes_per_row + col / 8 stays below 2^13.
  localparam int IDX_W = 14;

  // Colour code that is dithered to black and white.
  localparam logic [COLOR_W-1:0] GREY_CODE  = 16'h7BEF;
  localparam logic [COLOR_W-1:0] COLOR_BLK  = 16'h0000;
  localparam logic [COLOR_W-1:0] COLOR_WHT  = 16'hFFFF;

  // Register reset values.
  localparam logic [7:0]         CENTRE_X_RST = 8'd100;
  localparam logic [7:0]         CENTRE_Y_RST = 8'd100;
  localparam logic [TRIG_W-1:0]  COS_RST      = 16'h4000;
  localparam logic [TRIG_W-1:0]  SIN_RST      = 16'h0000;
  localparam logic [7:0]         WIDTH_RST    = 8'd8;
  localparam logic [7:0]         HEIGHT_RST   = 8'd8;
  localparam logic [COLOR_W-1:0] COLOR_RST    = 16'h0000;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CENTRE_X   = 3'd0,
    REG_CENTRE_Y   = 3'd1,
    REG_COS        = 3'd2,
    REG_SIN        = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5,
    REG_DRAW_COLOR = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         centre_x;
    logic [7:0]         centre_y;
    logic [TRIG_W-1:0]  cos_value;
    logic [TRIG_W-1:0]  sin_value;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [COLOR_W-1:0] draw_color;
  } cfg_t;

  // One accepted request as it enters the pipeline.
  typedef struct packed {
    logic                 valid;
    cmd_t                 command;
    logic [ADDR_IN_W-1:0] byte_address;
    logic [7:0]           byte_value;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
  } req_t;

  // Request as it reaches the sprite store.
  typedef struct packed {
    logic               valid;
    cmd_t               command;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         wdata;
    logic               on_sprite;
    logic [2:0]         bit_sel;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } lookup_t;

  typedef struct packed {
    logic               valid;
    logic               draw_enable;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COLOR_W-1:0] out_color;
  } res_t;

endpackage
`default_nettype wire

[src/rss_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_req_if
// Request channel: sprite byte loads and pixel samples, valid/ready.
// ----------------------------------------------------------------------------
interface rss_req_if;
  import rss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ADDR_IN_W-1:0] byte_address;
  logic [7:0]           byte_value;
  logic [COORD_W-1:0]   pixel_x;
  logic [COORD_W-1:0]   pixel_y;

  modport source (
    output valid, command, byte_address, byte_value, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, command, byte_address, byte_value, pixel_x, pixel_y,
    output ready
  );
endinterface
`default_nettype wire

[src/rss_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_res_if
// Result channel: one draw decision per sampled pixel, valid/ready.
// ----------------------------------------------------------------------------
interface rss_res_if;
  import rss_pkg::*;

  logic               valid;
  logic               ready;
  logic               draw_enable;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COLOR_W-1:0] out_color;

  modport source (
    output valid, draw_enable, out_x, out_y, out_color,
    input  ready
  );

  modport sink (
    input  valid, draw_enable, out_x, out_y, out_color,
    output ready
  );
endinterface
`default_nettype wire

[src/rss_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module rss_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [rss_pkg::TRIG_W-1:0]  cfg_wdata,
  output rss_pkg::cfg_t                    cfg
);
  import rss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTRE_X:   cfg_nxt.centre_x      = cfg_wdata[7:0];
        REG_CENTRE_Y:   cfg_nxt.centre_y      = cfg_wdata[7:0];
        REG_COS:        cfg_nxt.cos_value     = cfg_wdata;
        REG_SIN:        cfg_nxt.sin_value     = cfg_wdata;
        REG_WIDTH:      cfg_nxt.sprite_width  = cfg_wdata[7:0];
        REG_HEIGHT:     cfg_nxt.sprite_height = cfg_wdata[7:0];
        REG_DRAW_COLOR: cfg_nxt.draw_color    = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_x      <= CENTRE_X_RST;
      cfg_r.centre_y      <= CENTRE_Y_RST;
      cfg_r.cos_value     <= COS_RST;
      cfg_r.sin_value     <= SIN_RST;
      cfg_r.sprite_width  <= WIDTH_RST;
      cfg_r.sprite_height <= HEIGHT_RST;
      cfg_r.draw_color    <= COLOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[src/rss_geom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_geom
// Six-stage transform pipeline: pixel offset, inverse rotation, bounds test
// and sprite byte index. Loads ride along unchanged to keep request order.
// ----------------------------------------------------------------------------
module rss_geom (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rss_pkg::req_t    req,
  input  wire rss_pkg::cfg_t    cfg,
  output rss_pkg::lookup_t      lk
);
  import rss_pkg::*;

  localparam int NSTG = 5;

  req_t car_r [NSTG];

  logic signed [8:0]  dx1_r, dy1_r;
  logic signed [8:0]  dx_nxt, dy_nxt;
  logic signed [24:0] pxc2_r, pys2_r, pyc2_r, pxs2_r;
  logic signed [25:0] uxs3_r, uys3_r;
  logic signed [25:0] uxs_nxt, uys_nxt;
  logic signed [25:0] uxb, uyb;
  logic signed [11:0] ux4_r, uy4_r;
  logic signed [11:0] colf, rowf;
  logic [7:0]         col5_r, row5_r;
  logic               on_sprite5_r, on_sprite_nxt;
  logic [5:0]         bw;
  logic [IDX_W-1:0]   idx_smp;
  lookup_t            lk_r, lk_nxt;

  always_comb begin
    dx_nxt = $signed({1'b0, req.pixel_x}) - $signed({1'b0, cfg.centre_x});
    dy_nxt = $signed({1'b0, req.pixel_y}) - $signed({1'b0, cfg.centre_y});

    uxs_nxt = {pxc2_r[24], pxc2_r} + {pys2_r[24], pys2_r};
    uys_nxt = {pyc2_r[24], pyc2_r} - {pxs2_r[24], pxs2_r};

    // Negative sums get a bias of 2^14 - 1 so the shift truncates toward zero.
    uxb = uxs3_r + (uxs3_r[25] ? 26'sd16383 : 26'sd0);
    uyb = uys3_r + (uys3_r[25] ? 26'sd16383 : 26'sd0);

    colf = ux4_r + $signed({5'd0, cfg.sprite_width[7:1]});
    rowf = uy4_r + $signed({4'd0, cfg.sprite_height});
    on_sprite_nxt = !colf[11] && (colf < $signed({4'd0, cfg.sprite_width})) &&
                    !rowf[11] && uy4_r[11];

    bw = 6'((9'(cfg.sprite_width) + 9'd7) >> 3);
    idx_smp = IDX_W'(row5_r) * IDX_W'(bw) + IDX_W'(col5_r[7:3]);

    lk_nxt.valid     = car_r[NSTG-1].valid;
    lk_nxt.command   = car_r[NSTG-1].command;
    lk_nxt.idx       = (car_r[NSTG-1].command == CMD_LOAD) ?
                       IDX_W'(car_r[NSTG-1].byte_address) : idx_smp;
    lk_nxt.wdata     = car_r[NSTG-1].byte_value;
    lk_nxt.on_sprite = on_sprite5_r;
    lk_nxt.bit_sel   = col5_r[2:0];
    lk_nxt.pixel_x   = car_r[NSTG-1].pixel_x;
    lk_nxt.pixel_y   = car_r[NSTG-1].pixel_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        car_r[i].valid <= 1'b0;
      end
      lk_r.valid <= 1'b0;
    end else if (en) begin
      car_r[0] <= req;
      for (int i = 1; i < NSTG; i++) begin
        car_r[i] <= car_r[i-1];
      end
      lk_r <= lk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r        <= dx_nxt;
      dy1_r        <= dy_nxt;
      pxc2_r       <= dx1_r * $signed(cfg.cos_value);
      pys2_r       <= dy1_r * $signed(cfg.sin_value);
      pyc2_r       <= dy1_r * $signed(cfg.cos_value);
      pxs2_r       <= dx1_r * $signed(cfg.sin_value);
      uxs3_r       <= uxs_nxt;
      uys3_r       <= uys_nxt;
      ux4_r        <= uxb[25:Q_FRAC];
      uy4_r        <= uyb[25:Q_FRAC];
      col5_r       <= colf[7:0];
      row5_r       <= rowf[7:0];
      on_sprite5_r <= on_sprite_nxt;
    end
  end

  assign lk = lk_r;

endmodule
`default_nettype wire

[src/rss_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_store
// Sprite byte memory, written by loads and read by samples at the same
// pipeline stage, followed by the pixel test and colour selection.
// ----------------------------------------------------------------------------
module rss_store #(
  parameter int STORE_BYTES = rss_pkg::STORE_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rss_pkg::lookup_t lk,
  input  wire rss_pkg::cfg_t    cfg,
  output rss_pkg::res_t         res
);
  import rss_pkg::*;

  localparam int ADDR_W = $clog2(STORE_BYTES);

  logic [7:0]         mem [STORE_BYTES];
  logic [7:0]         rd_r;
  logic [31:0]        idx32;
  logic               in_store;
  logic               v7_r, hit7_r;
  logic [2:0]         bit7_r;
  logic [COORD_W-1:0] px7_r, py7_r;
  logic               draw;

  assign idx32    = 32'(lk.idx);
  assign in_store = idx32 < 32'(STORE_BYTES);

  always_ff @(posedge clk) begin
    if (en && lk.valid) begin
      if (lk.command == CMD_LOAD && in_store) begin
        mem[idx32[ADDR_W-1:0]] <= lk.wdata;
      end
      if (lk.command == CMD_SAMPLE) begin
        rd_r <= mem[idx32[ADDR_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= lk.valid && (lk.command == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit7_r <= lk.on_sprite && in_store;
      bit7_r <= lk.bit_sel;
      px7_r  <= lk.pixel_x;
      py7_r  <= lk.pixel_y;
    end
  end

  // The leftmost pixel of a byte is its most significant bit.
  assign draw = v7_r && hit7_r && !rd_r[3'd7 - bit7_r];

  always_comb begin
    res.valid       = v7_r;
    res.draw_enable = draw;
    res.out_x       = px7_r;
    res.out_y       = py7_r;
    if (!draw) begin
      res.out_color = COLOR_BLK;
    end else if (cfg.draw_color == GREY_CODE) begin
      res.out_color = (px7_r[0] ^ py7_r[0]) ? COLOR_WHT : COLOR_BLK;
    end else begin
      res.out_color = cfg.draw_color;
    end
  end

endmodule
`default_nettype wire

[src/rss_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rss_out_buf
// Output register with one skid entry; a full skid entry stalls the pipeline.
// ----------------------------------------------------------------------------
module rss_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rss_pkg::res_t res_in,
  input  wire logic          out_ready,
  output logic               out_valid,
  output rss_pkg::res_t      res_out,
  output logic               skid_full
);
  import rss_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  logic pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= res_in;
      end else begin
        out_r <= res_in;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = out_r;
  assign skid_full = skid_valid_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed while skid entry is full");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("stalled result was not captured in skid entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> !skid_valid_r)
    else $error("skid entry did not drain after output was taken");

endmodule
`default_nettype wire

[src/rotated_sprite_sampler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_sprite_sampler_core
// Rotated 1-bit sprite sampler: loads sprite bytes and answers pixel queries.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, a sprite byte load or a pixel
// sample, and returns one result for every sample and none for a load. A
// sample result passes through the transform registers (offset, four 9x16
// products, sums, truncation, bounds), the byte index register, the
// single-port sprite memory read and the output register. Loads travel the
// same pipeline and write the memory at the stage where samples read it, so
// a sample always sees every load that was requested before it. The pipeline
// only stops when the output register and its skid entry are both full;
// in_req.ready is a register output and does not depend on out_res.ready. The
// sprite memory is not cleared at reset and has no clearing pass: its bytes
// must be loaded before samples hit them. Configuration writes are meant for
// idle periods.
// ----------------------------------------------------------------------------
module rotated_sprite_sampler_core #(
  parameter int STORE_BYTES = rss_pkg::STORE_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [rss_pkg::TRIG_W-1:0] cfg_wdata,
  rss_req_if.sink                         in_req,
  rss_res_if.source                       out_res
);
  import rss_pkg::*;

  cfg_t    cfg;
  req_t    req;
  lookup_t lk;
  res_t    res_pipe;
  res_t    res_out;
  logic    en;
  logic    skid_full;
  logic    out_valid;

  // The whole pipeline advances together unless the skid entry is occupied.
  assign en           = !skid_full;
  assign in_req.ready = en;

  // A request only enters the pipeline at an accepting edge.
  always_comb begin
    req.valid        = in_req.valid;
    req.command      = cmd_t'(in_req.command);
    req.byte_address = in_req.byte_address;
    req.byte_value   = in_req.byte_value;
    req.pixel_x      = in_req.pixel_x;
    req.pixel_y      = in_req.pixel_y;
  end

  rss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rss_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (req),
    .cfg   (cfg),
    .lk    (lk)
  );

  rss_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .lk    (lk),
    .cfg   (cfg),
    .res   (res_pipe)
  );

  // A finished sample is handed over on the same edge the pipeline advances.
  rss_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en && res_pipe.valid),
    .res_in    (res_pipe),
    .out_ready (out_res.ready),
    .out_valid (out_valid),
    .res_out   (res_out),
    .skid_full (skid_full)
  );

  assign out_res.valid       = out_valid;
  assign out_res.draw_enable = res_out.draw_enable;
  assign out_res.out_x       = res_out.out_x;
  assign out_res.out_y       = res_out.out_y;
  assign out_res.out_color   = res_out.out_color;

endmodule
`default_nettype wire
